[src/timed_event_priority_queue_macros.svh]
`ifndef TIMED_EVENT_PRIORITY_QUEUE_MACROS_SVH
`define TIMED_EVENT_PRIORITY_QUEUE_MACROS_SVH

// check a property on every clock edge outside reset
`define TEPQ_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that a condition implies another one on the next clock edge
`define TEPQ_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) ante |=> cons) else $error(msg);

`endif

[src/tepq_pkg.sv]
package tepq_pkg;

   localparam int CAPACITY = 64;
   localparam int INDEX_W  = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int OCC_W    = 7;

   localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);
   localparam logic [31:0]        SIGN_BIAS = 32'h8000_0000;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic [63:0] ev_time;
      logic [31:0] ev_prio;
      logic [63:0] ev_seq;
      logic [31:0] ev_tag;
   } entry_type;

   typedef struct packed {
      logic               en;
      logic [INDEX_W-1:0] addr;
      entry_type          data;
   } mem_write_type;

   typedef struct packed {
      logic               en;
      logic [INDEX_W-1:0] addr;
   } mem_read_type;

endpackage

[src/tepq_mem.sv]
module tepq_mem (
   input  logic                    clock,
   input  tepq_pkg::mem_write_type wr,
   input  tepq_pkg::mem_read_type  rd,
   output tepq_pkg::entry_type     rd_data
);

   tepq_pkg::entry_type mem [tepq_pkg::CAPACITY];
   tepq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/tepq_cmp.sv]
module tepq_cmp (
   input  tepq_pkg::entry_type a,
   input  tepq_pkg::entry_type b,
   output logic                a_first
);

   logic [31:0] pa;
   logic [31:0] pb;

   always_comb begin
      pa = a.ev_prio ^ tepq_pkg::SIGN_BIAS;
      pb = b.ev_prio ^ tepq_pkg::SIGN_BIAS;
      if (a.ev_time != b.ev_time) begin
         a_first = a.ev_time < b.ev_time;
      end else if (pa != pb) begin
         a_first = pa < pb;
      end else begin
         a_first = a.ev_seq < b.ev_seq;
      end
   end

endmodule

[src/timed_event_priority_queue.sv]
// Channel       Ports                        Transaction taken when
// request       start, busy, req_*           start high and busy low at a clock edge
// response      rsp_strobe, rsp_*            rsp_strobe high for one cycle
//
// A push, a pop on an empty queue and a refused push answer on the cycle after acceptance.
// A pop scans the held entries through one comparator, one memory read per cycle, and
// keeps busy high until the scan is done; the response shows on the cycle busy falls.
// Reset is synchronous and empties the queue; the entry memory is not cleared.
// The response cannot be stalled; each one stands for exactly one cycle.
module timed_event_priority_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_opcode,
   input  logic [63:0]         req_event_time_ns,
   input  logic signed [31:0]  req_event_priority,
   input  logic [31:0]         req_event_tag,
   output logic                rsp_strobe,
   output logic [1:0]          rsp_status,
   output logic                rsp_out_valid,
   output logic [63:0]         rsp_out_time_ns,
   output logic signed [31:0]  rsp_out_priority,
   output logic [31:0]         rsp_out_tag,
   output logic [6:0]          rsp_occupancy
);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type                        state_ff, state_in;
   logic [tepq_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic [63:0]                      seq_ff, seq_in;
   logic [tepq_pkg::COUNT_W-1:0]     idx_ff, idx_in;
   logic                             dvld_ff, dvld_in;
   logic [tepq_pkg::INDEX_W-1:0]     didx_ff, didx_in;
   logic [tepq_pkg::INDEX_W-1:0]     bidx_ff, bidx_in;
   tepq_pkg::entry_type              best_ff, best_in;
   tepq_pkg::entry_type              last_ff, last_in;
   logic                             strobe_ff, strobe_in;
   tepq_pkg::status_type             status_ff, status_in;
   logic                             ovalid_ff, ovalid_in;
   logic [63:0]                      otime_ff, otime_in;
   logic [31:0]                      oprio_ff, oprio_in;
   logic [31:0]                      otag_ff, otag_in;
   logic [tepq_pkg::OCC_W-1:0]       occ_ff, occ_in;

   logic                             accept;
   logic                             cand_first;
   logic [tepq_pkg::INDEX_W-1:0]     last_idx;
   tepq_pkg::entry_type              rd_data;
   tepq_pkg::mem_write_type          mem_wr;
   tepq_pkg::mem_read_type           mem_rd;

   tepq_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd      (mem_rd),
      .rd_data (rd_data)
   );

   tepq_cmp u_cmp (
      .a       (rd_data),
      .b       (best_ff),
      .a_first (cand_first)
   );

   assign busy     = (state_ff == ST_SCAN);
   assign accept   = start && !busy;
   assign last_idx = tepq_pkg::INDEX_W'(count_ff - tepq_pkg::COUNT_W'(1));

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      seq_in    = seq_ff;
      idx_in    = idx_ff;
      dvld_in   = 1'b0;
      didx_in   = didx_ff;
      bidx_in   = bidx_ff;
      best_in   = best_ff;
      last_in   = last_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      ovalid_in = ovalid_ff;
      otime_in  = otime_ff;
      oprio_in  = oprio_ff;
      otag_in   = otag_ff;
      mem_wr    = '0;
      mem_rd    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ovalid_in = 1'b0;
               otime_in  = '0;
               oprio_in  = '0;
               otag_in   = '0;
               if (req_opcode == tepq_pkg::OP_PUSH) begin
                  strobe_in = 1'b1;
                  if (count_ff >= tepq_pkg::CAP_COUNT) begin
                     status_in = tepq_pkg::STATUS_FULL;
                  end else begin
                     status_in           = tepq_pkg::STATUS_OK;
                     mem_wr.en           = 1'b1;
                     mem_wr.addr         = tepq_pkg::INDEX_W'(count_ff);
                     mem_wr.data.ev_time = req_event_time_ns;
                     mem_wr.data.ev_prio = req_event_priority;
                     mem_wr.data.ev_seq  = seq_ff;
                     mem_wr.data.ev_tag  = req_event_tag;
                     seq_in              = seq_ff + 64'd1;
                     count_in            = count_ff + tepq_pkg::COUNT_W'(1);
                  end
               end else if (count_ff == '0) begin
                  strobe_in = 1'b1;
                  status_in = tepq_pkg::STATUS_EMPTY;
               end else begin
                  state_in = ST_SCAN;
                  idx_in   = '0;
               end
            end
         end
         ST_SCAN: begin
            if (idx_ff != count_ff) begin
               mem_rd.en   = 1'b1;
               mem_rd.addr = tepq_pkg::INDEX_W'(idx_ff);
               idx_in      = idx_ff + tepq_pkg::COUNT_W'(1);
               dvld_in     = 1'b1;
               didx_in     = tepq_pkg::INDEX_W'(idx_ff);
            end
            if (dvld_ff) begin
               if ((didx_ff == '0) || cand_first) begin
                  best_in = rd_data;
                  bidx_in = didx_ff;
               end
               if (didx_ff == last_idx) begin
                  last_in = rd_data;
               end
            end
            if ((idx_ff == count_ff) && !dvld_ff) begin
               mem_wr.en   = 1'b1;
               mem_wr.addr = bidx_ff;
               mem_wr.data = last_ff;
               count_in    = count_ff - tepq_pkg::COUNT_W'(1);
               strobe_in   = 1'b1;
               status_in   = tepq_pkg::STATUS_OK;
               ovalid_in   = 1'b1;
               otime_in    = best_ff.ev_time;
               oprio_in    = best_ff.ev_prio;
               otag_in     = best_ff.ev_tag;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      occ_in = tepq_pkg::OCC_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         seq_ff    <= '0;
         idx_ff    <= '0;
         dvld_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         seq_ff    <= seq_in;
         idx_ff    <= idx_in;
         dvld_ff   <= dvld_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      didx_ff   <= didx_in;
      bidx_ff   <= bidx_in;
      best_ff   <= best_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      ovalid_ff <= ovalid_in;
      otime_ff  <= otime_in;
      oprio_ff  <= oprio_in;
      otag_ff   <= otag_in;
      occ_ff    <= occ_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_valid    = ovalid_ff;
   assign rsp_out_time_ns  = otime_ff;
   assign rsp_out_priority = oprio_ff;
   assign rsp_out_tag      = otag_ff;
   assign rsp_occupancy    = occ_ff;

endmodule

[src/tepq_checker.sv]
`include "timed_event_priority_queue_macros.svh"

module tepq_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       req_opcode,
   input logic       rsp_strobe,
   input logic [1:0] rsp_status,
   input logic       rsp_out_valid,
   input logic [6:0] rsp_occupancy
);

   logic push_accept;
   logic pop_start;
   logic pop_rsp;
   logic empty_rsp;
   logic empty_ok;

   assign push_accept = start && !busy && (req_opcode == tepq_pkg::OP_PUSH);
   assign pop_start   = start && (req_opcode == tepq_pkg::OP_POP);
   assign pop_rsp     = rsp_strobe && rsp_out_valid;
   assign empty_rsp   = rsp_strobe && (rsp_status == tepq_pkg::STATUS_EMPTY);
   assign empty_ok    = (rsp_occupancy == '0) && !rsp_out_valid;

   `TEPQ_CHECK_NEXT(a_push_answers_next, push_accept, rsp_strobe && !busy, "push not answered")
   `TEPQ_CHECK(a_busy_from_pop, $rose(busy) |-> $past(pop_start), "busy without a pop")
   `TEPQ_CHECK(a_strobe_idle, rsp_strobe |-> !busy, "response shown while busy")
   `TEPQ_CHECK(a_valid_ok, pop_rsp |-> rsp_status == tepq_pkg::STATUS_OK, "error status on pop")
   `TEPQ_CHECK(a_empty_zero, empty_rsp |-> empty_ok, "empty error with events held")

endmodule

bind timed_event_priority_queue tepq_checker u_checker (.*);
